FILE: rtl/lls_pkg.sv
// ----------------------------------------------------------------------------
// LED level store package
// Shared constants, codes and types of the LED level store and packetizer.
// ----------------------------------------------------------------------------
`default_nettype none

package lls_pkg;

	// Number of 4-bit levels in the store. The store is kept as rows of eight
	// levels, so that one row read gives four payload bytes.
	localparam int LED_COUNT = 512;
	localparam int ROW_LEDS  = 8;
	localparam int ROWS      = (LED_COUNT + ROW_LEDS - 1) / ROW_LEDS;
	localparam int ROW_AW    = $clog2(ROWS);
	localparam int CNT_W     = ROW_AW + 1;
	localparam int ROW_W     = ROW_LEDS * 4;
	localparam int IDX_W     = 15;
	localparam int FL_ROW_W  = 6;

	localparam logic [7:0] GRID_CMD = 8'h1A;
	localparam logic [7:0] RING_CMD = 8'h92;

	localparam logic [1:0] MODE_GRID = 2'd1;
	localparam logic [1:0] MODE_RING = 2'd2;

	localparam logic [7:0] MAX_RING = 8'd7;

	typedef enum logic [2:0] {
		OP_SET_GRID   = 3'd0,
		OP_SET_RING   = 3'd1,
		OP_CLEAR_RING = 3'd2,
		OP_CLEAR_ALL  = 3'd3,
		OP_MARK_GRID  = 3'd4,
		OP_MARK_RING  = 3'd5,
		OP_FLUSH      = 3'd6
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_RMW_RD,
		ST_RMW_WR,
		ST_FL_RDA,
		ST_FL_RDB,
		ST_FL_PUT
	} state_t;

	function automatic logic row_ok(input logic [FL_ROW_W-1:0] row);
		return CNT_W'(row) < CNT_W'(ROWS);
	endfunction

endpackage

`default_nettype wire

FILE: rtl/lls_if.sv
// ----------------------------------------------------------------------------
// LED level store channels
// Valid/ready channels for operation items and packet word items.
// ----------------------------------------------------------------------------
`default_nettype none

interface lls_in_if;
	logic       valid;
	logic       ready;
	logic [2:0] operation;
	logic [7:0] coord_a;
	logic [7:0] coord_b;
	logic [3:0] level;

	modport source (output valid, output operation, output coord_a, output coord_b,
		output level, input ready);
	modport sink (input valid, input operation, input coord_a, input coord_b,
		input level, output ready);
endinterface

interface lls_out_if;
	logic        valid;
	logic        ready;
	logic [7:0]  command_byte;
	logic [3:0]  first_arg;
	logic [3:0]  second_arg;
	logic [1:0]  word_index;
	logic [63:0] payload;
	logic        end_of_packet;
	logic        last;

	modport source (output valid, output command_byte, output first_arg,
		output second_arg, output word_index, output payload, output end_of_packet,
		output last, input ready);
	modport sink (input valid, input command_byte, input first_arg,
		input second_arg, input word_index, input payload, input end_of_packet,
		input last, output ready);
endinterface

`default_nettype wire

FILE: rtl/lls_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module lls_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

FILE: rtl/lls_seq.sv
// ----------------------------------------------------------------------------
// LED level store sequencer
// Steps the store's write and read ports through writes, clearing sweeps and flushes.
// ----------------------------------------------------------------------------
`default_nettype none

module lls_seq (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic [1:0]                  mode,
	lls_in_if.sink                           item_in,
	lls_out_if.source                        item_out,
	output      logic                        ram_we,
	output      logic [lls_pkg::ROW_AW-1:0]  ram_waddr,
	output      logic [lls_pkg::ROW_W-1:0]   ram_wdata,
	output      logic                        ram_re,
	output      logic [lls_pkg::ROW_AW-1:0]  ram_raddr,
	input  wire logic [lls_pkg::ROW_W-1:0]   ram_rdata
);

	lls_pkg::state_t state_q, state_d;

	logic                          grid_dirty_q, ring_dirty_q;
	logic [lls_pkg::CNT_W-1:0]     clr_row_q, clr_end_q;
	logic [lls_pkg::IDX_W-1:0]     idx_q;
	logic [3:0]                    level_q;
	logic [4:0]                    wcnt_q;
	logic                          fl_ring_q;
	logic [lls_pkg::ROW_W-1:0]     hi_q;
	logic                          a_ok_q, b_ok_q;
	logic                          out_valid_q;

	logic                          in_fire;
	logic [lls_pkg::IDX_W-1:0]     idx_sel;
	logic                          idx_ok;
	logic [lls_pkg::FL_ROW_W-1:0]  row_a, row_b;
	logic                          fl_last;
	logic                          out_free;
	logic [lls_pkg::ROW_W-1:0]     merged;

	logic ld_set, ld_clr_ring, ld_clr_all, set_gd, set_rd;
	logic start_grid, start_ring, clr_step, cap_a, cap_b, out_load;

	assign item_in.ready = (state_q == lls_pkg::ST_IDLE);
	assign in_fire       = item_in.valid && item_in.ready;
	assign out_free      = !out_valid_q || item_out.ready;

	always_comb begin
		if (item_in.operation == lls_pkg::OP_SET_GRID) begin
			idx_sel = lls_pkg::IDX_W'(item_in.coord_a)
				+ (lls_pkg::IDX_W'(item_in.coord_b) << 4);
		end else begin
			idx_sel = lls_pkg::IDX_W'(item_in.coord_b)
				+ (lls_pkg::IDX_W'(item_in.coord_a) << 6);
		end
	end
	assign idx_ok = idx_sel < lls_pkg::IDX_W'(lls_pkg::LED_COUNT);

	always_comb begin
		if (fl_ring_q) begin
			row_a = {wcnt_q[4:2], wcnt_q[1:0], 1'b0};
			row_b = {wcnt_q[4:2], wcnt_q[1:0], 1'b1};
			fl_last = (wcnt_q == 5'd31);
		end else begin
			row_a = {1'b0, wcnt_q[3], wcnt_q[1:0], 1'b0, wcnt_q[2]};
			row_b = {1'b0, wcnt_q[3], wcnt_q[1:0], 1'b1, wcnt_q[2]};
			fl_last = (wcnt_q == 5'd15);
		end
	end

	always_comb begin
		merged = ram_rdata;
		merged[{~idx_q[2:0], 2'b00} +: 4] = level_q;
	end

	always_comb begin
		state_d     = state_q;
		ram_we      = 1'b0;
		ram_waddr   = lls_pkg::ROW_AW'(idx_q[lls_pkg::IDX_W-1:3]);
		ram_wdata   = merged;
		ram_re      = 1'b0;
		ram_raddr   = lls_pkg::ROW_AW'(idx_q[lls_pkg::IDX_W-1:3]);
		ld_set      = 1'b0;
		ld_clr_ring = 1'b0;
		ld_clr_all  = 1'b0;
		set_gd      = 1'b0;
		set_rd      = 1'b0;
		start_grid  = 1'b0;
		start_ring  = 1'b0;
		clr_step    = 1'b0;
		cap_a       = 1'b0;
		cap_b       = 1'b0;
		out_load    = 1'b0;
		unique case (state_q)
			lls_pkg::ST_IDLE: begin
				if (in_fire) begin
					unique case (item_in.operation) inside
						lls_pkg::OP_SET_GRID, lls_pkg::OP_SET_RING: begin
							if (idx_ok) begin
								ld_set  = 1'b1;
								state_d = lls_pkg::ST_RMW_RD;
							end
						end
						lls_pkg::OP_CLEAR_RING: begin
							if (item_in.coord_a <= lls_pkg::MAX_RING) begin
								ld_clr_ring = 1'b1;
								state_d     = lls_pkg::ST_CLEAR;
							end
						end
						lls_pkg::OP_CLEAR_ALL: begin
							ld_clr_all = 1'b1;
							state_d    = lls_pkg::ST_CLEAR;
						end
						lls_pkg::OP_MARK_GRID: set_gd = 1'b1;
						lls_pkg::OP_MARK_RING: set_rd = 1'b1;
						lls_pkg::OP_FLUSH: begin
							if (mode == lls_pkg::MODE_GRID && grid_dirty_q) begin
								start_grid = 1'b1;
								state_d    = lls_pkg::ST_FL_RDA;
							end else if (mode == lls_pkg::MODE_RING && ring_dirty_q) begin
								start_ring = 1'b1;
								state_d    = lls_pkg::ST_FL_RDA;
							end
						end
						default: ;
					endcase
				end
			end
			lls_pkg::ST_CLEAR: begin
				ram_we    = (clr_row_q < lls_pkg::CNT_W'(lls_pkg::ROWS));
				ram_waddr = lls_pkg::ROW_AW'(clr_row_q);
				ram_wdata = '0;
				clr_step  = 1'b1;
				if (clr_row_q == clr_end_q) begin
					state_d = lls_pkg::ST_IDLE;
				end
			end
			lls_pkg::ST_RMW_RD: begin
				ram_re  = 1'b1;
				state_d = lls_pkg::ST_RMW_WR;
			end
			lls_pkg::ST_RMW_WR: begin
				ram_we  = 1'b1;
				state_d = lls_pkg::ST_IDLE;
			end
			lls_pkg::ST_FL_RDA: begin
				ram_re    = 1'b1;
				ram_raddr = lls_pkg::ROW_AW'(row_a);
				cap_a     = 1'b1;
				state_d   = lls_pkg::ST_FL_RDB;
			end
			lls_pkg::ST_FL_RDB: begin
				ram_re    = 1'b1;
				ram_raddr = lls_pkg::ROW_AW'(row_b);
				cap_b     = 1'b1;
				state_d   = lls_pkg::ST_FL_PUT;
			end
			lls_pkg::ST_FL_PUT: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = fl_last ? lls_pkg::ST_IDLE : lls_pkg::ST_FL_RDA;
				end
			end
			default: state_d = lls_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lls_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_dirty_q <= 1'b0;
			ring_dirty_q <= 1'b0;
			clr_row_q    <= '0;
			clr_end_q    <= lls_pkg::CNT_W'(lls_pkg::ROWS - 1);
			wcnt_q       <= '0;
			fl_ring_q    <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (set_gd || start_grid) begin
				grid_dirty_q <= set_gd;
			end
			if (set_rd || start_ring) begin
				ring_dirty_q <= set_rd;
			end
			if (ld_clr_ring) begin
				clr_row_q <= lls_pkg::CNT_W'({item_in.coord_a[2:0], 3'b000});
				clr_end_q <= lls_pkg::CNT_W'({item_in.coord_a[2:0], 3'b111});
			end else if (ld_clr_all) begin
				clr_row_q <= '0;
				clr_end_q <= lls_pkg::CNT_W'(lls_pkg::ROWS - 1);
			end else if (clr_step) begin
				clr_row_q <= clr_row_q + 1'b1;
			end
			if (start_grid || start_ring) begin
				wcnt_q    <= '0;
				fl_ring_q <= start_ring;
			end else if (out_load) begin
				wcnt_q <= wcnt_q + 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (item_out.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld_set) begin
			idx_q   <= idx_sel;
			level_q <= item_in.level;
		end
		if (cap_a) begin
			a_ok_q <= lls_pkg::row_ok(row_a);
		end
		if (cap_b) begin
			b_ok_q <= lls_pkg::row_ok(row_b);
			hi_q   <= a_ok_q ? ram_rdata : '0;
		end
		if (out_load) begin
			item_out.payload    <= {hi_q, b_ok_q ? ram_rdata : lls_pkg::ROW_W'(0)};
			item_out.word_index <= wcnt_q[1:0];
			item_out.end_of_packet <= &wcnt_q[1:0];
			item_out.last       <= fl_last;
			if (fl_ring_q) begin
				item_out.command_byte <= lls_pkg::RING_CMD;
				item_out.first_arg    <= {1'b0, wcnt_q[4:2]};
				item_out.second_arg   <= 4'd0;
			end else begin
				item_out.command_byte <= lls_pkg::GRID_CMD;
				item_out.first_arg    <= {wcnt_q[2], 3'b000};
				item_out.second_arg   <= {wcnt_q[3], 3'b000};
			end
		end
	end

	assign item_out.valid = out_valid_q;

endmodule

`default_nettype wire

FILE: rtl/led_level_store_packetizer.sv
// A set reads the row that holds the level and writes it back merged; a ring clear zeroes
// that ring's eight rows, and a full clear all ROWS rows (64 at 512 LEDs). A flush reads
// two rows of eight levels for each payload word, one row of eight levels per access.
// Input items are taken one at a time; a finished word waits in the output register.
// After reset the store is swept to zero, all ROWS rows (64 at 512 LEDs),
// during which no item is taken; mode and both dirty flags reset to zero.
// ----------------------------------------------------------------------------
// LED level store and packetizer
// Holds LED brightness levels and sends grid quadrant or ring packets on flush.
// ----------------------------------------------------------------------------
`default_nettype none

module led_level_store_packetizer (
	input  wire logic       clk,
	input  wire logic       arst_n,
	lls_in_if.sink          item_in,
	lls_out_if.source       item_out,
	input  wire logic       cfg_we,
	input  wire logic [1:0] cfg_data
);

	logic [1:0]                    mode_q;
	logic                          ram_we, ram_re;
	logic [lls_pkg::ROW_AW-1:0]    ram_waddr, ram_raddr;
	logic [lls_pkg::ROW_W-1:0]     ram_wdata, ram_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 2'd0;
		end else if (cfg_we) begin
			mode_q <= cfg_data;
		end
	end

	lls_ram #(
		.WIDTH (lls_pkg::ROW_W),
		.DEPTH (lls_pkg::ROWS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	lls_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.mode      (mode_q),
		.item_in   (item_in),
		.item_out  (item_out),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata)
	);

	a_eop_word: assert property (@(posedge clk) disable iff (!arst_n)
		item_out.valid |-> (item_out.end_of_packet == (item_out.word_index == 2'd3)))
		else $error("end_of_packet does not match the word index");

	a_last_eop: assert property (@(posedge clk) disable iff (!arst_n)
		item_out.valid && item_out.last |-> item_out.end_of_packet)
		else $error("last item is not the end of a packet");

	a_ring_args: assert property (@(posedge clk) disable iff (!arst_n)
		item_out.valid && item_out.command_byte == lls_pkg::RING_CMD
		|-> item_out.second_arg == 4'd0 && !item_out.first_arg[3])
		else $error("ring packet arguments out of range");

	a_no_store_clash: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> !ram_re)
		else $error("store written and read in the same cycle");

endmodule

`default_nettype wire

FILE: bench/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// LED level store and packetizer testbench
// Sends set, clear, mark and flush operations under several mode settings,
// with random gaps on the input side and random stalls on the output side.
// The bench keeps its own copy of the level store and dirty flags. From that
// copy it works out every packet word a flush should send, and it compares
// each word the block sends with the oldest word still due.
// ----------------------------------------------------------------------------

module tb;

	localparam logic [2:0] OP_UNUSED     = 3'd7;
	localparam logic [1:0] MODE_OFF      = 2'd0;
	localparam logic [1:0] MODE_SPARE    = 2'd3;
	localparam int         RING_LEDS     = 64;
	localparam int         SETTLE_CYCLES = 100;
	localparam int         HOLD_CYCLES   = 400;
	localparam int         HOLD_AFTER    = 64;
	localparam int         PHASES        = 8;
	localparam int         PHASE_OPS     = 50;

	typedef enum logic [1:0] {
		ENT_OP,
		ENT_MODE,
		ENT_PAUSE
	} entry_kind_t;

	typedef struct {
		entry_kind_t kind;
		logic [2:0]  op;
		logic [7:0]  coord_a;
		logic [7:0]  coord_b;
		logic [3:0]  level;
		logic [1:0]  mode;
		int          gap;
	} entry_t;

	typedef struct {
		logic [7:0]  command_byte;
		logic [3:0]  first_arg;
		logic [3:0]  second_arg;
		logic [1:0]  word_index;
		logic [63:0] payload;
		logic        end_of_packet;
		logic        last;
	} pkt_word_t;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       cfg_we;
	logic [1:0] cfg_data;

	lls_in_if  in_ch();
	lls_out_if out_ch();

	led_level_store_packetizer uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.item_in  (in_ch),
		.item_out (out_ch),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data)
	);

	logic [3:0] level_map [lls_pkg::LED_COUNT];
	logic       grid_marked;
	logic       ring_marked;
	logic [1:0] cur_mode;

	entry_t    op_queue [$];
	pkt_word_t words_due [$];

	logic      no_gap;
	int        ops_total;
	int        ops_taken;
	int        words_seen;
	int        mismatches;

	entry_t    head;
	logic      offering;
	logic      write_mode;
	int        gap_count;
	int        settle_count;
	int        stall_left;
	int        hold_left;
	logic      hold_used;
	logic      long_hold;
	pkt_word_t want;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic logic [3:0] level_at(int idx);
		return (idx < lls_pkg::LED_COUNT) ? level_map[idx] : 4'd0;
	endfunction

	task automatic apply_store_op(input logic [2:0] op, input logic [7:0] a,
		input logic [7:0] b, input logic [3:0] lv);
		int idx;
		logic [3:0] qx;
		logic [3:0] qy;
		logic [63:0] pay;
		pkt_word_t word;
		case (op)
			lls_pkg::OP_SET_GRID: begin
				idx = int'(a) + (int'(b) << 4);
				if (idx < lls_pkg::LED_COUNT)
					level_map[idx] = lv;
			end
			lls_pkg::OP_SET_RING: begin
				idx = int'(b) + (int'(a) << 6);
				if (idx < lls_pkg::LED_COUNT)
					level_map[idx] = lv;
			end
			lls_pkg::OP_CLEAR_RING: begin
				if (a <= lls_pkg::MAX_RING) begin
					for (int i = 0; i < RING_LEDS; i++) begin
						idx = int'(a) * RING_LEDS + i;
						if (idx < lls_pkg::LED_COUNT)
							level_map[idx] = 4'd0;
					end
				end
			end
			lls_pkg::OP_CLEAR_ALL: begin
				for (int i = 0; i < lls_pkg::LED_COUNT; i++)
					level_map[i] = 4'd0;
			end
			lls_pkg::OP_MARK_GRID: grid_marked = 1'b1;
			lls_pkg::OP_MARK_RING: ring_marked = 1'b1;
			lls_pkg::OP_FLUSH: begin
				if (cur_mode == lls_pkg::MODE_GRID && grid_marked) begin
					for (int q = 0; q < 4; q++) begin
						qx = q[0] ? 4'd8 : 4'd0;
						qy = q[1] ? 4'd8 : 4'd0;
						for (int w = 0; w < 4; w++) begin
							pay = '0;
							for (int k = 0; k < 8; k++) begin
								idx = (int'(qy) + (w * 8 + k) / 4) * 16
									+ int'(qx) + ((w * 8 + k) % 4) * 2;
								pay = {pay[55:0], level_at(idx), level_at(idx + 1)};
							end
							word.command_byte  = lls_pkg::GRID_CMD;
							word.first_arg     = qx;
							word.second_arg    = qy;
							word.word_index    = w[1:0];
							word.payload       = pay;
							word.end_of_packet = (w == 3);
							word.last          = (q == 3 && w == 3);
							words_due.push_back(word);
						end
					end
					grid_marked = 1'b0;
				end else if (cur_mode == lls_pkg::MODE_RING && ring_marked) begin
					for (int r = 0; r < 8; r++) begin
						for (int w = 0; w < 4; w++) begin
							pay = '0;
							for (int k = 0; k < 8; k++) begin
								idx = r * RING_LEDS + (w * 8 + k) * 2;
								pay = {pay[55:0], level_at(idx), level_at(idx + 1)};
							end
							word.command_byte  = lls_pkg::RING_CMD;
							word.first_arg     = r[3:0];
							word.second_arg    = 4'd0;
							word.word_index    = w[1:0];
							word.payload       = pay;
							word.end_of_packet = (w == 3);
							word.last          = (r == 7 && w == 3);
							words_due.push_back(word);
						end
					end
					ring_marked = 1'b0;
				end
			end
			default: ;
		endcase
	endtask

	task automatic push_op(input logic [2:0] op, input int a, input int b, input int lv);
		entry_t e;
		e.kind    = ENT_OP;
		e.op      = op;
		e.coord_a = a[7:0];
		e.coord_b = b[7:0];
		e.level   = lv[3:0];
		e.mode    = MODE_OFF;
		e.gap     = no_gap ? 0 : $urandom_range(0, 11);
		op_queue.push_back(e);
		ops_total++;
	endtask

	task automatic push_mode(input logic [1:0] m);
		entry_t e;
		e.kind    = ENT_MODE;
		e.op      = OP_UNUSED;
		e.coord_a = '0;
		e.coord_b = '0;
		e.level   = '0;
		e.mode    = m;
		e.gap     = 0;
		op_queue.push_back(e);
	endtask

	task automatic push_pause();
		entry_t e;
		e.kind    = ENT_PAUSE;
		e.op      = OP_UNUSED;
		e.coord_a = '0;
		e.coord_b = '0;
		e.level   = '0;
		e.mode    = MODE_OFF;
		e.gap     = 0;
		op_queue.push_back(e);
	endtask

	task automatic check_field(input string name, input logic [63:0] exp_val,
		input logic [63:0] act_val);
		if (exp_val !== act_val) begin
			$error("%s mismatch: expected %0h, got %0h", name, exp_val, act_val);
			mismatches++;
		end
	endtask

	// Operation driver: config writes and pauses wait until no word is due.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			cfg_we <= 1'b0;
			offering = 1'b0;
			gap_count = 0;
			settle_count = 0;
		end else begin
			write_mode = 1'b0;
			if (in_ch.valid && in_ch.ready) begin
				apply_store_op(in_ch.operation, in_ch.coord_a, in_ch.coord_b, in_ch.level);
				ops_taken++;
				offering = 1'b0;
			end
			if (!offering && op_queue.size() > 0) begin
				head = op_queue[0];
				case (head.kind)
					ENT_OP: begin
						if (gap_count < head.gap) begin
							gap_count++;
						end else begin
							in_ch.operation <= head.op;
							in_ch.coord_a <= head.coord_a;
							in_ch.coord_b <= head.coord_b;
							in_ch.level <= head.level;
							offering = 1'b1;
							gap_count = 0;
							void'(op_queue.pop_front());
						end
					end
					ENT_MODE: begin
						if (words_due.size() != 0) begin
							settle_count = 0;
						end else if (settle_count < SETTLE_CYCLES) begin
							settle_count++;
						end else begin
							write_mode = 1'b1;
							cfg_data <= head.mode;
							cur_mode = head.mode;
							settle_count = 0;
							void'(op_queue.pop_front());
						end
					end
					ENT_PAUSE: begin
						if (words_due.size() == 0)
							void'(op_queue.pop_front());
					end
					default: ;
				endcase
			end
			in_ch.valid <= offering;
			cfg_we <= write_mode;
		end
	end

	// One long receiver hold-off once the first packets have gone through.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			long_hold <= 1'b0;
			hold_left = 0;
			hold_used = 1'b0;
		end else begin
			if (hold_left > 0) begin
				hold_left--;
			end else if (!hold_used && words_seen >= HOLD_AFTER) begin
				hold_left = HOLD_CYCLES;
				hold_used = 1'b1;
			end
			long_hold <= (hold_left > 0);
		end
	end

	// Packet word monitor.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
			stall_left = 0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				if (words_due.size() == 0) begin
					$error("packet word item arrived with no word due");
					mismatches++;
				end else begin
					want = words_due.pop_front();
					check_field("command_byte", want.command_byte, out_ch.command_byte);
					check_field("first_arg", want.first_arg, out_ch.first_arg);
					check_field("second_arg", want.second_arg, out_ch.second_arg);
					check_field("word_index", want.word_index, out_ch.word_index);
					check_field("payload", want.payload, out_ch.payload);
					check_field("end_of_packet", want.end_of_packet, out_ch.end_of_packet);
					check_field("last", want.last, out_ch.last);
				end
				words_seen++;
				stall_left = ((words_seen / 40) % 3 == 1) ? 0 : $urandom_range(0, 11);
			end else if (stall_left > 0) begin
				stall_left--;
			end
			out_ch.ready <= (stall_left == 0) && !long_hold;
		end
	end

	initial begin
		logic [1:0] phase_mode [PHASES];
		logic [1:0] m;
		logic mark_grid;
		int r;
		int a;
		int b;
		int lv;

		in_ch.valid = 1'b0;
		in_ch.operation = '0;
		in_ch.coord_a = '0;
		in_ch.coord_b = '0;
		in_ch.level = '0;
		out_ch.ready = 1'b0;
		cfg_we = 1'b0;
		cfg_data = '0;
		arst_n = 1'b0;

		for (int i = 0; i < lls_pkg::LED_COUNT; i++)
			level_map[i] = 4'd0;
		grid_marked = 1'b0;
		ring_marked = 1'b0;
		cur_mode = MODE_OFF;
		ops_total = 0;
		ops_taken = 0;
		words_seen = 0;
		mismatches = 0;
		no_gap = 1'b0;

		push_mode(lls_pkg::MODE_GRID);
		push_op(lls_pkg::OP_SET_GRID, 0, 0, 15);
		push_op(lls_pkg::OP_SET_GRID, 15, 15, 15);
		push_op(lls_pkg::OP_SET_GRID, 255, 255, 9);
		push_op(lls_pkg::OP_SET_GRID, 7, 31, 5);
		push_op(lls_pkg::OP_SET_RING, 7, 63, 12);
		push_op(lls_pkg::OP_SET_RING, 8, 0, 3);
		push_op(lls_pkg::OP_SET_RING, 255, 255, 1);
		push_op(lls_pkg::OP_SET_RING, 2, 10, 10);
		push_op(lls_pkg::OP_SET_RING, 0, 1, 6);
		push_op(lls_pkg::OP_MARK_GRID, 0, 0, 0);
		push_op(lls_pkg::OP_FLUSH, 0, 0, 0);
		push_op(lls_pkg::OP_FLUSH, 0, 0, 0);
		push_op(lls_pkg::OP_MARK_RING, 0, 0, 0);
		push_op(lls_pkg::OP_FLUSH, 0, 0, 0);
		push_op(lls_pkg::OP_CLEAR_RING, 2, 0, 0);
		push_op(lls_pkg::OP_CLEAR_RING, 8, 0, 0);
		push_op(lls_pkg::OP_CLEAR_RING, 255, 255, 15);
		push_op(OP_UNUSED, 255, 255, 15);
		push_op(lls_pkg::OP_MARK_GRID, 0, 0, 0);
		push_op(lls_pkg::OP_FLUSH, 0, 0, 0);
		push_mode(lls_pkg::MODE_RING);
		push_op(lls_pkg::OP_FLUSH, 0, 0, 0);
		push_op(lls_pkg::OP_CLEAR_ALL, 0, 0, 0);
		push_op(lls_pkg::OP_MARK_RING, 0, 0, 0);
		push_op(lls_pkg::OP_FLUSH, 0, 0, 0);
		// These items wait at the input while the long hold-off stalls the flush.
		push_op(lls_pkg::OP_SET_RING, 3, 5, 7);
		push_op(lls_pkg::OP_SET_GRID, 4, 4, 2);
		push_mode(MODE_OFF);
		push_op(lls_pkg::OP_MARK_GRID, 0, 0, 0);
		push_op(lls_pkg::OP_FLUSH, 0, 0, 0);

		phase_mode = '{lls_pkg::MODE_GRID, lls_pkg::MODE_RING, MODE_OFF, lls_pkg::MODE_GRID,
			MODE_SPARE, lls_pkg::MODE_RING, lls_pkg::MODE_GRID, lls_pkg::MODE_RING};
		for (int p = 0; p < PHASES; p++) begin
			m = phase_mode[p];
			push_mode(m);
			no_gap = (p % 3 == 1);
			for (int i = 0; i < PHASE_OPS; i++) begin
				if (p == 3 && i == PHASE_OPS / 2)
					push_pause();
				r = $urandom_range(0, 99);
				lv = $urandom_range(0, 15);
				if (r < 33) begin
					if ($urandom_range(0, 9) == 0) begin
						a = $urandom_range(0, 255);
						b = $urandom_range(0, 255);
					end else begin
						a = $urandom_range(0, 15);
						b = $urandom_range(0, 15);
					end
					push_op(lls_pkg::OP_SET_GRID, a, b, lv);
				end else if (r < 56) begin
					if ($urandom_range(0, 9) == 0) begin
						a = $urandom_range(0, 255);
						b = $urandom_range(0, 255);
					end else begin
						a = $urandom_range(0, 7);
						b = $urandom_range(0, 63);
					end
					push_op(lls_pkg::OP_SET_RING, a, b, lv);
				end else if (r < 61) begin
					a = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255)
						: $urandom_range(0, 9);
					push_op(lls_pkg::OP_CLEAR_RING, a, $urandom_range(0, 255), lv);
				end else if (r < 63) begin
					push_op(lls_pkg::OP_CLEAR_ALL, $urandom_range(0, 255),
						$urandom_range(0, 255), lv);
				end else if (r < 76) begin
					mark_grid = (m == lls_pkg::MODE_GRID);
					if ($urandom_range(0, 4) == 0)
						mark_grid = !mark_grid;
					push_op(mark_grid ? lls_pkg::OP_MARK_GRID : lls_pkg::OP_MARK_RING,
						$urandom_range(0, 255), $urandom_range(0, 255), lv);
				end else if (r < 90) begin
					push_op(lls_pkg::OP_FLUSH, $urandom_range(0, 255),
						$urandom_range(0, 255), lv);
				end else if (r < 92) begin
					push_op(OP_UNUSED, $urandom_range(0, 255), $urandom_range(0, 255), lv);
				end else begin
					push_op($urandom_range(0, 7), $urandom_range(0, 255),
						$urandom_range(0, 255), lv);
				end
			end
		end

		repeat (4) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (ops_taken < ops_total || op_queue.size() != 0)
			@(posedge clk);
		while (words_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule
